// File: sv/mandel_pkg.sv
package mandel_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int MAX_DIM_DEF    = 4096;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_CFG_W = 13;
  localparam int ITER_W    = 8;
  localparam int COPY_W    = 3;
  localparam int COPY_CNT_W = 2;
  localparam logic [COPY_W-1:0] MAX_COPIES = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RE_ORIGIN = 3'd0,
    REG_IM_ORIGIN = 3'd1,
    REG_RE_STEP   = 3'd2,
    REG_IM_STEP   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5,
    REG_MAX_ITER  = 3'd6,
    REG_BPP       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]     re_origin;
    logic [CFG_W-1:0]     im_origin;
    logic [CFG_W-1:0]     re_step;
    logic [CFG_W-1:0]     im_step;
    logic [DIM_CFG_W-1:0] width;
    logic [DIM_CFG_W-1:0] height;
    logic [ITER_W-1:0]    max_iter;
    logic [COPY_W-1:0]    bytes_per_pixel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    re_origin:       32'(-475124531),
    im_origin:       32'd322122547,
    re_step:         32'd212087,
    im_step:         32'(-214748),
    width:           13'd3000,
    height:          13'd3000,
    max_iter:        8'd255,
    bytes_per_pixel: 3'd3
  };

  // microprogram addresses
  typedef enum logic [2:0] {
    STEP_IDLE    = 3'd0,
    STEP_SQ_RE   = 3'd1,
    STEP_SQ_IM   = 3'd2,
    STEP_TEST    = 3'd3,
    STEP_UPDATE  = 3'd4,
    STEP_EMIT    = 3'd5,
    STEP_ADVANCE = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_ALWAYS      = 3'd1,
    COND_NO_INPUT    = 3'd2,
    COND_OUT_BUSY    = 3'd3,
    COND_EXIT        = 3'd4,
    COND_MORE_COPIES = 3'd5
  } cond_t;

  typedef enum logic [1:0] {
    MUL_RR = 2'd0,
    MUL_II = 2'd1,
    MUL_RI = 2'd2
  } mul_sel_t;

  typedef struct packed {
    cond_t    stall;
    cond_t    jump;
    step_t    target;
    mul_sel_t mul;
    logic     cap_sr;
    logic     cap_si;
    logic     load;
    logic     upd_z;
    logic     emit;
    logic     adv;
  } ucode_t;

  typedef struct packed {
    mul_sel_t mul;
    logic     cap_sr;
    logic     cap_si;
    logic     load;
    logic     upd_z;
    logic     emit;
    logic     adv;
    logic     idle;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic exit;
    logic more_copies;
  } status_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              last_byte;
    logic              row_end;
    logic              frame_end;
  } res_t;

endpackage

// File: sv/mandel_seq.sv
module mandel_seq import mandel_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  pc;
  step_t  pc_next;
  ucode_t uc;
  logic   stall;
  logic   jump;

  function automatic logic cond_true(input cond_t c, input status_t s);
    logic r;
    case (c)
      COND_NEVER:       r = 1'b0;
      COND_ALWAYS:      r = 1'b1;
      COND_NO_INPUT:    r = !s.in_valid;
      COND_OUT_BUSY:    r = s.out_busy;
      COND_EXIT:        r = s.exit;
      COND_MORE_COPIES: r = s.more_copies;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // control store
  function automatic ucode_t ucode_at(input step_t s);
    ucode_t u;
    u = '0;
    case (s)
      STEP_IDLE: begin
        u.stall = COND_NO_INPUT;
        u.load  = 1'b1;
      end
      STEP_SQ_RE: begin
        u.mul = MUL_RR;
      end
      STEP_SQ_IM: begin
        u.mul    = MUL_II;
        u.cap_sr = 1'b1;
      end
      STEP_TEST: begin
        u.mul    = MUL_RI;
        u.cap_si = 1'b1;
        u.jump   = COND_EXIT;
        u.target = STEP_EMIT;
      end
      STEP_UPDATE: begin
        u.upd_z  = 1'b1;
        u.jump   = COND_ALWAYS;
        u.target = STEP_SQ_RE;
      end
      STEP_EMIT: begin
        u.stall  = COND_OUT_BUSY;
        u.emit   = 1'b1;
        u.jump   = COND_MORE_COPIES;
        u.target = STEP_EMIT;
      end
      STEP_ADVANCE: begin
        u.adv    = 1'b1;
        u.jump   = COND_ALWAYS;
        u.target = STEP_IDLE;
      end
      default: begin
        u.jump   = COND_ALWAYS;
        u.target = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

  always_comb begin
    uc    = ucode_at(pc);
    stall = cond_true(uc.stall, status);
    jump  = cond_true(uc.jump, status);
    if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = uc.target;
    end else begin
      pc_next = step_t'(pc + 3'd1);
    end
    ctrl.mul    = uc.mul;
    ctrl.cap_sr = uc.cap_sr && !stall;
    ctrl.cap_si = uc.cap_si && !stall;
    ctrl.load   = uc.load   && !stall;
    ctrl.upd_z  = uc.upd_z  && !stall;
    ctrl.emit   = uc.emit   && !stall;
    ctrl.adv    = uc.adv    && !stall;
    ctrl.idle   = (pc == STEP_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: sv/mandel_dp.sv
module mandel_dp import mandel_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  ctrl_t ctrl,
  input  logic  restart,
  output logic  exit,
  output logic  more_copies,
  output res_t  res
);

  localparam int CB    = COORD_BITS;
  localparam int F     = CB - 4;
  localparam int PW    = 2 * CB;
  localparam int SW    = PW + 1;
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DW0   = ($clog2(MAX_DIM + 1) > DIM_CFG_W) ? $clog2(MAX_DIM + 1) : DIM_CFG_W;
  localparam int DIM_W = DW0 + 1;
  localparam logic [PW-1:0]    LIMIT   = PW'(1) << (2 * F + 2);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic signed [CB-1:0] zr, zi, cur_re, cur_im;
  logic signed [PW-1:0] prod, sr, si;
  logic [ITER_W-1:0]    it;
  logic [CNT_W-1:0]     col, row;
  logic [COPY_CNT_W-1:0] k;

  logic signed [CB-1:0] re_org, im_org, re_stp, im_stp;
  logic signed [CB-1:0] ma, mb;
  logic signed [SW-1:0] diff, re_sum, im_sum;
  logic [PW-1:0]        mag;
  logic [DIM_W-1:0]     w_raw, h_raw, w_eff, h_eff;
  logic                 rend, fend;
  logic [COPY_W-1:0]    copies;
  logic                 last_copy;

  function automatic logic signed [CB-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-CB:0] top;
    logic signed [CB-1:0] r;
    top = v[SW-1:CB-1];
    if ((&top) || (~|top)) begin
      r = v[CB-1:0];
    end else if (v[SW-1]) begin
      r = {1'b1, {(CB-1){1'b0}}};
    end else begin
      r = {1'b0, {(CB-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    re_org = CB'($signed(cfg.re_origin));
    im_org = CB'($signed(cfg.im_origin));
    re_stp = CB'($signed(cfg.re_step));
    im_stp = CB'($signed(cfg.im_step));

    case (ctrl.mul)
      MUL_RR:  begin ma = zr; mb = zr; end
      MUL_II:  begin ma = zi; mb = zi; end
      MUL_RI:  begin ma = zr; mb = zi; end
      default: begin ma = zr; mb = zi; end
    endcase

    // escape test: prod holds zi^2 during the test step
    mag  = sr + prod;
    exit = (mag >= LIMIT) || (it >= cfg.max_iter);

    // next z; prod holds zr*zi during the update step
    diff   = SW'(sr) - SW'(si);
    re_sum = (diff >>> F) + SW'(cur_re);
    im_sum = (SW'(prod) >>> (F - 1)) + SW'(cur_im);

    w_raw = DIM_W'(cfg.width);
    h_raw = DIM_W'(cfg.height);
    w_eff = (w_raw == '0) ? DIM_W'(1) : ((w_raw > DIM_MAX) ? DIM_MAX : w_raw);
    h_eff = (h_raw == '0) ? DIM_W'(1) : ((h_raw > DIM_MAX) ? DIM_MAX : h_raw);
    rend  = (DIM_W'(col) + DIM_W'(1)) >= w_eff;
    fend  = rend && ((DIM_W'(row) + DIM_W'(1)) >= h_eff);

    if (cfg.bytes_per_pixel == '0) begin
      copies = COPY_W'(1);
    end else if (cfg.bytes_per_pixel > MAX_COPIES) begin
      copies = MAX_COPIES;
    end else begin
      copies = cfg.bytes_per_pixel;
    end
    last_copy   = (COPY_W'(k) == (copies - COPY_W'(1)));
    more_copies = !last_copy;

    res.iter_count = it;
    res.last_byte  = last_copy;
    res.row_end    = rend;
    res.frame_end  = fend;
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= PW'(ma) * PW'(mb);
    if (ctrl.cap_sr) begin
      sr <= prod;
    end
    if (ctrl.cap_si) begin
      si <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zr     <= '0;
      zi     <= '0;
      it     <= '0;
      k      <= '0;
      col    <= '0;
      row    <= '0;
      cur_re <= CB'($signed(CFG_RESET.re_origin));
      cur_im <= CB'($signed(CFG_RESET.im_origin));
    end else begin
      if (ctrl.load) begin
        it <= '0;
        k  <= '0;
        if (restart) begin
          col    <= '0;
          row    <= '0;
          cur_re <= re_org;
          cur_im <= im_org;
          zr     <= re_org;
          zi     <= im_org;
        end else begin
          zr <= cur_re;
          zi <= cur_im;
        end
      end
      if (ctrl.upd_z) begin
        zr <= sat(re_sum);
        zi <= sat(im_sum);
        it <= it + ITER_W'(1);
      end
      if (ctrl.emit) begin
        k <= last_copy ? '0 : k + COPY_CNT_W'(1);
      end
      if (ctrl.adv) begin
        if (!rend) begin
          col    <= col + CNT_W'(1);
          cur_re <= cur_re + re_stp;
        end else begin
          col    <= '0;
          cur_re <= re_org;
          if (fend) begin
            row    <= '0;
            cur_im <= im_org;
          end else begin
            row    <= row + CNT_W'(1);
            cur_im <= cur_im + im_stp;
          end
        end
      end
    end
  end

endmodule

// File: sv/mandelbrot_escape_raster_core.sv
// Mandelbrot escape-time raster core. Every request on the slave stream asks
// for the next pixel of a raster (s_tdata[0] set restarts the raster at the
// origin first). The core iterates z = z*z + c in signed Q4.(COORD_BITS-4)
// starting from z = c, stops when |z|^2 reaches 4 or the count reaches
// max_iter, and returns the count as bytes_per_pixel copies (1 to 4) on the
// master stream, tlast on the final copy, tuser carrying row and frame ends.
// A small microprogram steps one shared COORD_BITS x COORD_BITS multiplier:
// every iteration steps through zr^2, zi^2, zr*zi with the escape test,
// then the update. One pixel is in work at a time; the next request is
// taken once the last copy sits in the output register, even if the sink
// has not yet taken it. Configuration writes take effect at once and must
// be made while the core is idle; a new real origin applies at the next row
// end, a new imaginary origin at the next frame end, both at a restart.
module mandelbrot_escape_raster_core import mandel_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // pixel requests
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] restart, [7:1] zero
  // pixel bytes
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] iter_count
  output logic                 m_tlast,   // last_byte
  output logic [1:0]           m_tuser,   // [0] row_end, [1] frame_end
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;
  res_t    res;
  res_t    out_res;
  logic    out_valid;
  logic    exit;
  logic    more_copies;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_RE_ORIGIN: cfg.re_origin       <= cfg_data;
        REG_IM_ORIGIN: cfg.im_origin       <= cfg_data;
        REG_RE_STEP:   cfg.re_step         <= cfg_data;
        REG_IM_STEP:   cfg.im_step         <= cfg_data;
        REG_WIDTH:     cfg.width           <= cfg_data[DIM_CFG_W-1:0];
        REG_HEIGHT:    cfg.height          <= cfg_data[DIM_CFG_W-1:0];
        REG_MAX_ITER:  cfg.max_iter        <= cfg_data[ITER_W-1:0];
        REG_BPP:       cfg.bytes_per_pixel <= cfg_data[COPY_W-1:0];
        default: ;
      endcase
    end
  end

  // the sequencer stalls on the emit step while the output register is full
  // and not being drained this cycle
  always_comb begin
    status.in_valid    = s_tvalid;
    status.out_busy    = out_valid && !m_tready;
    status.exit        = exit;
    status.more_copies = more_copies;
  end

  mandel_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mandel_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .restart     (s_tdata[0]),
    .exit        (exit),
    .more_copies (more_copies),
    .res         (res)
  );

  // output register: load a copy on emit, drop it when the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_res <= res;
    end
  end

  assign s_tready = ctrl.idle;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.iter_count;
  assign m_tlast  = out_res.last_byte;
  assign m_tuser  = {out_res.frame_end, out_res.row_end};

endmodule

// File: sv/mandel_chk.sv
module mandel_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output byte changed while stalled");

  // copies of a pixel still pending: no new request may be taken
  a_busy_copies: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request taken while copies of a pixel are pending");

  // one pixel in work at a time
  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken right after the first");

  // a frame end is also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tuser[1] || m_tuser[0])
    else $error("frame end without row end");

endmodule

bind mandelbrot_escape_raster_core mandel_chk u_chk (.*);

// File: tb/sv/mandelbrot_escape_raster_core_tb.sv
module mandelbrot_escape_raster_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mandel_pkg::*;

  // Q4.28 helpers: one unit, fraction width, escape bound |z|^2 >= 4 at Q8.56
  localparam int FRAC = COORD_BITS_DEF - 4;
  localparam int ONE  = 1 << FRAC;
  localparam longint unsigned ESC_LIM = 64'd4 << (2 * FRAC);

  // worst pixel (limit 255) plus the sink's stalls on four bytes and the
  // source gap; ~430 pixels of that, taken several times over
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic [1:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  mandelbrot_escape_raster_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pixel requests waiting to go out (each entry is the restart flag), and
  // the bytes the raster should return, oldest first.
  bit   pixel_reqs[$];
  res_t pixel_bytes_due[$];

  // Shadow of the raster state and the registers as the core should hold them.
  cfg_t              shadow_cfg = CFG_RESET;
  logic signed [31:0] c_re = CFG_RESET.re_origin;
  logic signed [31:0] c_im = CFG_RESET.im_origin;
  int                col_pos = 0;
  int                row_pos = 0;

  int  fails = 0;
  int  cycles = 0;
  int  src_wait = 0;
  int  snk_wait = 0;
  bit  src_calm = 1'b0;
  bit  snk_calm = 1'b0;

  function automatic logic signed [31:0] sat_coord(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int clamp_dim(input logic [DIM_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  // Escape-time count for point c: z starts at c, squares are exact at Q8.56
  // and each new component is floored back to Q4.28, added to c, saturated.
  function automatic logic [ITER_W-1:0] escape_count(input logic signed [31:0] cre,
                                                     input logic signed [31:0] cim,
                                                     input logic [ITER_W-1:0] lim);
    longint zr, zi, sr, si, p;
    longint unsigned mag;
    int it;
    bit done;
    zr = cre;
    zi = cim;
    it = 0;
    done = 1'b0;
    while (!done && it < lim) begin
      sr = zr * zr;
      si = zi * zi;
      mag = sr + si;
      if (mag >= ESC_LIM) begin
        done = 1'b1;
      end else begin
        p  = zr * zi;
        zr = sat_coord(((sr - si) >>> FRAC) + cre);
        zi = sat_coord((p >>> (FRAC - 1)) + cim);
        it++;
      end
    end
    return it[ITER_W-1:0];
  endfunction

  // Work out the bytes of one pixel request and advance the raster position.
  task automatic predict_pixel(input bit restart);
    int w, h, copies;
    logic [ITER_W-1:0] cnt;
    bit rend, fend;
    w = clamp_dim(shadow_cfg.width);
    h = clamp_dim(shadow_cfg.height);
    copies = int'(shadow_cfg.bytes_per_pixel);
    if (copies == 0) copies = 1;
    if (copies > int'(MAX_COPIES)) copies = int'(MAX_COPIES);
    if (restart) begin
      col_pos = 0;
      row_pos = 0;
      c_re = shadow_cfg.re_origin;
      c_im = shadow_cfg.im_origin;
    end
    cnt = escape_count(c_re, c_im, shadow_cfg.max_iter);
    // a counter already past a shrunken bound also ends its row or frame
    rend = (col_pos + 1 >= w);
    fend = rend && (row_pos + 1 >= h);
    for (int k = 0; k < copies; k++)
      pixel_bytes_due.push_back('{iter_count: cnt, last_byte: (k == copies - 1),
                                  row_end: rend, frame_end: fend});
    if (!rend) begin
      col_pos++;
      c_re = c_re + $signed(shadow_cfg.re_step);
    end else begin
      col_pos = 0;
      c_re = shadow_cfg.re_origin;
      if (fend) begin
        row_pos = 0;
        c_im = shadow_cfg.im_origin;
      end else begin
        row_pos++;
        c_im = c_im + $signed(shadow_cfg.im_step);
      end
    end
  endtask

  // Source side: present queued requests, predict each one as it is taken,
  // hold a drawn gap between requests. tvalid stays high across back-to-back
  // requests so it never sees two assignments in one step.
  always @(posedge clk) begin : drive
    int gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (s_tvalid && s_tready) begin
      predict_pixel(s_tdata[0]);
      gap = src_calm ? 0 : $urandom_range(0, 16);
      if (gap == 0 && pixel_reqs.size() != 0) begin
        s_tdata <= {7'd0, pixel_reqs.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
        src_wait <= gap;
      end
    end else if (!s_tvalid) begin
      if (src_wait != 0) begin
        src_wait <= src_wait - 1;
      end else if (pixel_reqs.size() != 0) begin
        s_tdata  <= {7'd0, pixel_reqs.pop_front()};
        s_tvalid <= 1'b1;
      end
    end
  end

  // Sink side: check every byte taken against the oldest due byte, then
  // drop tready for a randomly drawn wait unless it comes out zero.
  always @(posedge clk) begin : watch
    res_t want;
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      snk_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      if (pixel_bytes_due.size() == 0) begin
        $error("byte with nothing due: iter_count %0d", m_tdata);
        fails++;
      end else begin
        want = pixel_bytes_due.pop_front();
        if (m_tdata !== want.iter_count) begin
          $error("iter_count: expected %0d, got %0d", want.iter_count, m_tdata);
          fails++;
        end
        if (m_tlast !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, m_tlast);
          fails++;
        end
        if (m_tuser[0] !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, m_tuser[0]);
          fails++;
        end
        if (m_tuser[1] !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, m_tuser[1]);
          fails++;
        end
      end
      gap = snk_calm ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        m_tready <= 1'b0;
        snk_wait <= gap;
      end
    end else if (!m_tready) begin
      if (snk_wait != 0) snk_wait <= snk_wait - 1;
      else m_tready <= 1'b1;
    end
  end

  // Watchdog: a missing byte leaves the drain waiting forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("mandelbrot_escape_raster_core: mismatch");
      $finish;
    end
  end

  // Write all eight registers, one per edge, and mirror them in the shadow.
  task automatic apply_cfg(input cfg_t c);
    reg_idx_t idx;
    logic [CFG_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_RE_ORIGIN: v = c.re_origin;
        REG_IM_ORIGIN: v = c.im_origin;
        REG_RE_STEP:   v = c.re_step;
        REG_IM_STEP:   v = c.im_step;
        REG_WIDTH:     v = CFG_W'(c.width);
        REG_HEIGHT:    v = CFG_W'(c.height);
        REG_MAX_ITER:  v = CFG_W'(c.max_iter);
        default:       v = CFG_W'(c.bytes_per_pixel);
      endcase
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_addr <= idx;
      cfg_data <= v;
    end
    shadow_cfg = c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is taken and every due byte has come back, then
  // let the core settle into idle.
  task automatic drain();
    while (pixel_reqs.size() != 0 || s_tvalid || pixel_bytes_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    src_calm = ($urandom_range(0, 3) == 0);
    snk_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic queue_pixels(input int n);
    for (int i = 0; i < n; i++)
      pixel_reqs.push_back($urandom_range(0, 9) == 0);
    drain();
  endtask

  // Mostly small rasters and small limits so row and frame ends come often;
  // now and then a full-range register value or a deep limit.
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.re_origin = ($urandom_range(0, 7) == 0) ? $urandom()
                : $urandom_range(0, 939524096) - 671088640;
    c.im_origin = ($urandom_range(0, 7) == 0) ? $urandom()
                : $urandom_range(0, 805306368) - 402653184;
    c.re_step   = ($urandom_range(0, 7) == 0) ? $urandom()
                : $urandom_range(0, 1 << 26) - (1 << 25);
    c.im_step   = ($urandom_range(0, 7) == 0) ? $urandom()
                : $urandom_range(0, 1 << 26) - (1 << 25);
    c.width     = ($urandom_range(0, 7) == 0) ? DIM_CFG_W'($urandom_range(0, 8191))
                : DIM_CFG_W'($urandom_range(1, 8));
    c.height    = ($urandom_range(0, 7) == 0) ? DIM_CFG_W'(0)
                : DIM_CFG_W'($urandom_range(1, 5));
    c.max_iter  = ($urandom_range(0, 5) == 0) ? ITER_W'(255)
                : ITER_W'($urandom_range(0, 48));
    c.bytes_per_pixel = COPY_W'($urandom_range(0, 7));
    return c;
  endfunction

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: first pixels off the corner of the default view,
    // a restart in the middle.
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b1);
    pixel_reqs.push_back(1'b0);
    drain();

    // One-pixel frame: every pixel ends row and frame, c reloads each time.
    // The origin sits in the set, so the count runs to the full limit.
    c = CFG_RESET;
    c.re_origin = 32'd0;
    c.im_origin = 32'd0;
    c.re_step   = 32'd0;
    c.im_step   = 32'd0;
    c.width     = DIM_CFG_W'(1);
    c.height    = DIM_CFG_W'(1);
    c.max_iter  = ITER_W'(255);
    c.bytes_per_pixel = MAX_COPIES;
    apply_cfg(c);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b1);
    drain();

    // Zero limit, zero copies, zero dimensions: count 0 whatever the point.
    c.max_iter  = ITER_W'(0);
    c.bytes_per_pixel = COPY_W'(0);
    c.width     = DIM_CFG_W'(0);
    c.height    = DIM_CFG_W'(0);
    c.im_origin = 32'h7fffffff;
    apply_cfg(c);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    drain();

    // Extreme coordinates and steps so c wraps; oversized raster, copy count
    // above the cap.
    c.re_origin = 32'h7fffffff;
    c.im_origin = 32'h80000000;
    c.re_step   = 32'h7fffffff;
    c.im_step   = 32'h80000000;
    c.width     = DIM_CFG_W'(8191);
    c.height    = DIM_CFG_W'(4096);
    c.max_iter  = ITER_W'(1);
    c.bytes_per_pixel = COPY_W'(7);
    apply_cfg(c);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    drain();

    // 3 x 2 raster near the main cardioid: row ends and a restart in the
    // middle of a row.
    c.re_origin = 32'(-(3 * ONE / 4));
    c.im_origin = 32'(ONE / 10);
    c.re_step   = 32'(ONE / 4);
    c.im_step   = 32'(-(ONE / 10));
    c.width     = DIM_CFG_W'(3);
    c.height    = DIM_CFG_W'(2);
    c.max_iter  = ITER_W'(30);
    c.bytes_per_pixel = COPY_W'(1);
    apply_cfg(c);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b1);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    drain();

    // Shrink the raster under a running column: the next pixel is past the
    // width, on the last row, and must end its row and the frame.
    c.width     = DIM_CFG_W'(4);
    c.height    = DIM_CFG_W'(3);
    c.max_iter  = ITER_W'(12);
    c.bytes_per_pixel = COPY_W'(2);
    apply_cfg(c);
    pixel_reqs.push_back(1'b1);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    drain();
    c.width     = DIM_CFG_W'(2);
    c.height    = DIM_CFG_W'(1);
    apply_cfg(c);
    pixel_reqs.push_back(1'b0);
    pixel_reqs.push_back(1'b0);
    drain();

    // Random settings, each followed by a run of pixel requests.
    for (int ph = 0; ph < 8; ph++) begin
      apply_cfg(random_cfg());
      queue_pixels(50);
    end

    // Let any stray byte show up before the verdict.
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("mandelbrot_escape_raster_core: match");
    end else begin
      $display("mandelbrot_escape_raster_core: mismatch");
    end
    $finish;
  end

endmodule
